>>> src/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants of the Bresenham line rasterizer
// Holds the payload structs of both channels, the queued line record, the
// register indexes and the walker state type.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

  localparam int COORD_BITS   = 6;
  localparam int COLOR_BITS   = 32;
  localparam int CFG_BITS     = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam int ADDR_BITS    = 2 * COORD_BITS;
  localparam int PROD_BITS    = COORD_BITS + CFG_BITS;
  // The error term stays within twice the longest delta; e2 needs one more bit.
  localparam int ERR_BITS     = COORD_BITS + 3;
  localparam int E2_BITS      = ERR_BITS + 1;
  localparam int CMD_DEPTH    = 2;
  localparam int PTR_BITS     = 1;
  localparam int CNT_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FB_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FB_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_BITS-1:0]     FB_WIDTH_RST  = CFG_BITS'(64);
  localparam logic [CFG_BITS-1:0]     FB_HEIGHT_RST = CFG_BITS'(64);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } cmd_in_t;

  typedef struct packed {
    coord_t                 pixel_x;
    coord_t                 pixel_y;
    logic [ADDR_BITS-1:0]   pixel_address;
    color_t                 pixel_color;
    logic                   in_bounds;
    logic                   last;
  } pixel_t;

  // Line as classified by the front end and walked by the back end.
  typedef struct packed {
    coord_t                    cur_x;
    coord_t                    cur_y;
    coord_t                    end_x;
    coord_t                    end_y;
    coord_t                    dx;
    coord_t                    dy;
    logic                      step_x_neg;
    logic                      step_y_neg;
    logic signed [ERR_BITS-1:0] err;
    color_t                    color;
  } line_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_t;

endpackage

`default_nettype wire

>>> src/brl_front.sv
// ----------------------------------------------------------------------------
// brl_front: line request classifier
// Computes the deltas, step directions and initial error term of a line
// request and hands the finished record to the line queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_front
  import brl_pkg::*;
(
  input  wire cmd_in_t cmd,
  output line_t        line
);

  coord_t dx;
  coord_t dy;

  always_comb begin
    dx = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x : cmd.start_x - cmd.end_x;
    dy = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y : cmd.start_y - cmd.end_y;
    line.cur_x      = cmd.start_x;
    line.cur_y      = cmd.start_y;
    line.end_x      = cmd.end_x;
    line.end_y      = cmd.end_y;
    line.dx         = dx;
    line.dy         = dy;
    line.step_x_neg = !(cmd.start_x < cmd.end_x);
    line.step_y_neg = !(cmd.start_y < cmd.end_y);
    line.err        = $signed(ERR_BITS'(dx)) - $signed(ERR_BITS'(dy));
    line.color      = cmd.line_color;
  end

endmodule

`default_nettype wire

>>> src/brl_line_fifo.sv
// ----------------------------------------------------------------------------
// brl_line_fifo: short queue of classified lines
// Decouples request intake from the pixel walker so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_line_fifo
  import brl_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         wr_en,
  input  wire line_t  wr_data,
  input  wire         rd_en,
  output line_t       rd_data,
  output logic        full,
  output logic        empty
);

  line_t                mem_r [CMD_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count_r == CNT_BITS'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> src/brl_walker.sv
// ----------------------------------------------------------------------------
// brl_walker: Bresenham pixel walker
// Loads one queued line, then steps the error term once per cycle while the
// output register is free or drained, writing pixel, address and bounds flag.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_walker
  import brl_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [CFG_BITS-1:0]  fb_width,
  input  wire [CFG_BITS-1:0]  fb_height,
  input  wire line_t          line_in,
  input  wire                 line_empty,
  output logic                line_pop,
  output pixel_t              pix_out,
  output logic                pix_empty,
  input  wire                 pix_pop
);

  walk_state_t state_r, state_nxt;
  line_t       line_r, line_nxt;
  pixel_t      pix_r, pix_nxt;
  logic        pix_valid_r, pix_valid_nxt;

  logic                       emit;
  logic                       done;
  logic                       step_x;
  logic                       step_y;
  logic signed [E2_BITS-1:0]  e2;
  logic signed [E2_BITS-1:0]  dx_e;
  logic signed [E2_BITS-1:0]  dy_e;
  logic signed [E2_BITS-1:0]  err_sum;
  logic [PROD_BITS-1:0]       prod;
  logic [PROD_BITS-1:0]       x_ext;
  logic [PROD_BITS-1:0]       y_ext;

  assign pix_out   = pix_r;
  assign pix_empty = !pix_valid_r;
  assign done      = (line_r.cur_x == line_r.end_x) && (line_r.cur_y == line_r.end_y);
  // A pixel leaves the walker when the output register is free or being drained.
  assign emit      = (state_r == WALK_RUN) && (!pix_valid_r || pix_pop);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WALK_IDLE: begin
        if (!line_empty) begin
          state_nxt = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (emit && done) begin
          state_nxt = WALK_IDLE;
        end
      end
      default: state_nxt = WALK_IDLE;
    endcase
  end

  always_comb begin
    dx_e    = $signed(E2_BITS'(line_r.dx));
    dy_e    = $signed(E2_BITS'(line_r.dy));
    e2      = $signed({line_r.err, 1'b0});
    step_x  = e2 > -dy_e;
    step_y  = e2 < dx_e;
    err_sum = E2_BITS'(line_r.err) - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);

    x_ext = PROD_BITS'(line_r.cur_x);
    y_ext = PROD_BITS'(line_r.cur_y);
    prod  = y_ext * PROD_BITS'(fb_width);

    pix_nxt.pixel_x       = line_r.cur_x;
    pix_nxt.pixel_y       = line_r.cur_y;
    pix_nxt.pixel_address = ADDR_BITS'(prod + x_ext);
    pix_nxt.pixel_color   = line_r.color;
    pix_nxt.in_bounds     = (x_ext < PROD_BITS'(fb_width)) && (y_ext < PROD_BITS'(fb_height));
    pix_nxt.last          = done;

    line_pop      = 1'b0;
    line_nxt      = line_r;
    pix_valid_nxt = pix_valid_r;
    if (pix_pop) begin
      pix_valid_nxt = 1'b0;
    end
    unique case (state_r)
      WALK_IDLE: begin
        if (!line_empty) begin
          line_pop = 1'b1;
          line_nxt = line_in;
        end
      end
      WALK_RUN: begin
        if (emit) begin
          pix_valid_nxt = 1'b1;
          if (!done) begin
            line_nxt.err = ERR_BITS'(err_sum);
            if (step_x) begin
              line_nxt.cur_x = line_r.step_x_neg ? line_r.cur_x - 1'b1 : line_r.cur_x + 1'b1;
            end
            if (step_y) begin
              line_nxt.cur_y = line_r.step_y_neg ? line_r.cur_y - 1'b1 : line_r.cur_y + 1'b1;
            end
          end
        end
      end
      default: begin
        line_nxt = line_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WALK_IDLE;
      pix_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pix_valid_r <= pix_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
    if (emit) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: line request to pixel stream rasterizer
// Accepts line requests, queues them, and emits every pixel of each line
// with its framebuffer address, color, bounds flag and last marker.
//
//   Channel   Ports                          Moves
//   input     push, full, in_cmd             one line request
//   output    empty, pop, out_pixel          one pixel of a line
//   config    cfg_wr_en, cfg_index, cfg_wdata  framebuffer width and height
//
// A line of max(|dx|,|dy|)+1 pixels is loaded from the two-entry line queue
// while the walker is idle. The walker advances one pixel per cycle while
// the output register is free or being popped, limited by the single
// error-term update and the y*width multiply feeding the output register.
// Reset clears the queue, walker state and output valid, and restores width
// and height to 64. A stalled pop holds the output register and the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer
  import brl_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  output logic                    full,
  input  wire cmd_in_t            in_cmd,
  output logic                    empty,
  input  wire                     pop,
  output pixel_t                  out_pixel,
  input  wire                     cfg_wr_en,
  input  wire [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [CFG_BITS-1:0]      cfg_wdata
);

  logic [CFG_BITS-1:0] fb_width_r, fb_width_nxt;
  logic [CFG_BITS-1:0] fb_height_r, fb_height_nxt;
  line_t               front_line;
  line_t               queue_line;
  logic                queue_empty;
  logic                queue_pop;

  always_comb begin
    fb_width_nxt  = fb_width_r;
    fb_height_nxt = fb_height_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FB_WIDTH:  fb_width_nxt  = cfg_wdata;
        REG_FB_HEIGHT: fb_height_nxt = cfg_wdata;
        default: begin
          fb_width_nxt = fb_width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r  <= FB_WIDTH_RST;
      fb_height_r <= FB_HEIGHT_RST;
    end else begin
      fb_width_r  <= fb_width_nxt;
      fb_height_r <= fb_height_nxt;
    end
  end

  brl_front u_front (
    .cmd  (in_cmd),
    .line (front_line)
  );

  brl_line_fifo u_line_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_line),
    .rd_en   (queue_pop),
    .rd_data (queue_line),
    .full    (full),
    .empty   (queue_empty)
  );

  brl_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .fb_width   (fb_width_r),
    .fb_height  (fb_height_r),
    .line_in    (queue_line),
    .line_empty (queue_empty),
    .line_pop   (queue_pop),
    .pix_out    (out_pixel),
    .pix_empty  (empty),
    .pix_pop    (pop)
  );

endmodule

`default_nettype wire

>>> verif/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer: self-checking bench for the line rasterizer
// Sends line requests through the push/full side and pops pixels from the
// empty/pop side. Each accepted request is walked by a local Bresenham
// predictor, and every popped pixel is compared field by field with the
// oldest predicted pixel. Several framebuffer sizes are used: reset, zero,
// one, the largest register value, a random size and two mixes. Both sides
// idle at random; two long receiver stalls back the queue up into the input.
// ----------------------------------------------------------------------------

module tb_bresenham_line_rasterizer;
  import brl_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_LINES = 30;

  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    int     fb_width;
    int     fb_height;
    int     errors;

    function new();
      fb_width  = 64;
      fb_height = 64;
      errors    = 0;
    endfunction

    function void set_size(int w, int h);
      fb_width  = w;
      fb_height = h;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Walks the line exactly as the block should and queues every pixel.
    function void note_line(cmd_in_t c);
      int     cx, cy, ex, ey, dx, dy, step_x, step_y, err, e2;
      pixel_t p;
      cx = c.start_x;
      cy = c.start_y;
      ex = c.end_x;
      ey = c.end_y;
      dx = (ex > cx) ? ex - cx : cx - ex;
      dy = (ey > cy) ? ey - cy : cy - ey;
      step_x = (cx < ex) ? 1 : -1;
      step_y = (cy < ey) ? 1 : -1;
      err = dx - dy;
      forever begin
        p.pixel_x       = COORD_BITS'(cx);
        p.pixel_y       = COORD_BITS'(cy);
        p.pixel_address = ADDR_BITS'(cy * fb_width + cx);
        p.pixel_color   = c.line_color;
        p.in_bounds     = (cx < fb_width) && (cy < fb_height);
        p.last          = (cx == ex) && (cy == ey);
        expected_pixels.push_back(p);
        if (p.last) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          cx += step_x;
        end
        if (e2 < dx) begin
          err += dx;
          cy += step_y;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      string  bad;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) popped with nothing expected",
                         got.pixel_x, got.pixel_y));
        return;
      end
      want = expected_pixels.pop_front();
      bad  = "";
      if (got.pixel_x !== want.pixel_x) bad = {bad, " pixel_x"};
      if (got.pixel_y !== want.pixel_y) bad = {bad, " pixel_y"};
      if (got.pixel_address !== want.pixel_address) bad = {bad, " pixel_address"};
      if (got.pixel_color !== want.pixel_color) bad = {bad, " pixel_color"};
      if (got.in_bounds !== want.in_bounds) bad = {bad, " in_bounds"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "")
        report({$sformatf("bad%s: got (%0d,%0d) a=%0d c=%h b=%b l=%b,",
                          bad, got.pixel_x, got.pixel_y, got.pixel_address,
                          got.pixel_color, got.in_bounds, got.last),
                $sformatf(" want (%0d,%0d) a=%0d c=%h b=%b l=%b",
                          want.pixel_x, want.pixel_y, want.pixel_address,
                          want.pixel_color, want.in_bounds, want.last)});
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    push;
  logic                    full;
  cmd_in_t                 in_cmd;
  logic                    empty;
  logic                    pop;
  pixel_t                  out_pixel;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  pixel_scoreboard sb;
  int              tx_idle_pct;
  int              rx_idle_pct;
  bit              hold_req;
  int              stall_cycles;

  bresenham_line_rasterizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_cmd    (in_cmd),
    .empty     (empty),
    .pop       (pop),
    .out_pixel (out_pixel),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Ends the run if neither side moves anything for too long.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Pixel side: random pops, with one long hold-off when asked for.
  initial begin
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
      if (pop && !empty) sb.check_pixel(out_pixel);
    end
  end

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Mostly short lines; some full-range, corner, degenerate and axis lines.
  function automatic cmd_in_t random_line();
    cmd_in_t c;
    int      kind, sx, sy, ex, ey, span;
    kind = $urandom_range(99);
    sx = $urandom_range(COORD_MAX);
    sy = $urandom_range(COORD_MAX);
    if (kind < 15) begin
      ex = $urandom_range(COORD_MAX);
      ey = $urandom_range(COORD_MAX);
    end else if (kind < 25) begin
      sx = $urandom_range(1) * COORD_MAX;
      sy = $urandom_range(1) * COORD_MAX;
      ex = $urandom_range(1) * COORD_MAX;
      ey = $urandom_range(1) * COORD_MAX;
    end else if (kind < 33) begin
      ex = sx;
      ey = sy;
    end else if (kind < 45) begin
      span = $urandom_range(40) - 20;
      case ($urandom_range(2))
        0: begin
          ex = clamp_coord(sx + span);
          ey = sy;
        end
        1: begin
          ex = sx;
          ey = clamp_coord(sy + span);
        end
        default: begin
          if (sx + span < 0 || sx + span > COORD_MAX || sy + span < 0 ||
              sy + span > COORD_MAX) span = -span;
          if (sx + span < 0 || sx + span > COORD_MAX || sy + span < 0 ||
              sy + span > COORD_MAX) span = 0;
          ex = sx + span;
          ey = sy + span;
        end
      endcase
    end else begin
      ex = clamp_coord(sx + $urandom_range(16) - 8);
      ey = clamp_coord(sy + $urandom_range(16) - 8);
    end
    c.start_x    = COORD_BITS'(sx);
    c.start_y    = COORD_BITS'(sy);
    c.end_x      = COORD_BITS'(ex);
    c.end_y      = COORD_BITS'(ey);
    c.line_color = $urandom();
    return c;
  endfunction

  task automatic send_line(cmd_in_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    in_cmd <= c;
    do @(posedge clk); while (full);
    sb.note_line(c);
  endtask

  task automatic send_points(int sx, int sy, int ex, int ey, logic [COLOR_BITS-1:0] color);
    cmd_in_t c;
    c.start_x    = COORD_BITS'(sx);
    c.start_y    = COORD_BITS'(sy);
    c.end_x      = COORD_BITS'(ex);
    c.end_y      = COORD_BITS'(ey);
    c.line_color = color;
    send_line(c);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block idle; the predictor follows the new size.
  task automatic set_framebuffer(int w, int h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FB_WIDTH;
    cfg_wdata <= CFG_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_FB_HEIGHT;
    cfg_wdata <= CFG_BITS'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_size(w, h);
  endtask

  initial begin
    int phase_w[6];
    int phase_h[6];
    sb = new();
    hold_req    = 1'b0;
    tx_idle_pct = 30;
    rx_idle_pct = 57;
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_cmd    <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_FB_WIDTH;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners, diagonals, axis lines, steep and shallow slopes, points.
    send_points(0, 0, 63, 63, 32'h0000_0000);
    send_points(63, 63, 0, 0, 32'hFFFF_FFFF);
    send_points(0, 63, 63, 0, 32'hA5A5_A5A5);
    send_points(63, 0, 0, 63, 32'h5A5A_5A5A);
    send_points(0, 0, 0, 0, 32'h0123_4567);
    send_points(63, 63, 63, 63, 32'h89AB_CDEF);
    send_points(0, 5, 63, 5, 32'h1111_1111);
    send_points(63, 40, 0, 40, 32'h2222_2222);
    send_points(7, 0, 7, 63, 32'h3333_3333);
    send_points(50, 63, 50, 0, 32'h4444_4444);
    send_points(3, 0, 5, 63, 32'h8000_0001);
    send_points(0, 3, 63, 5, 32'h7FFF_FFFE);
    send_points(60, 2, 10, 9, 32'hDEAD_BEEF);
    send_points(10, 50, 12, 20, 32'hCAFE_F00D);
    send_points(20, 20, 21, 22, 32'h0F0F_0F0F);
    send_points(31, 32, 32, 31, 32'hF0F0_F0F0);
    send_points(1, 1, 2, 1, 32'h0000_FFFF);
    send_points(62, 0, 63, 63, 32'hFFFF_0000);
    drain();

    // One, zero, the largest register value, a random size, then two mixes.
    phase_w = '{1, 0, 127, 1 + $urandom_range(63), 64, 40};
    phase_h = '{1, 0, 127, 1 + $urandom_range(63), 17, 64};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 30;
        rx_idle_pct = 57;
      end else if (ph < 4) begin
        tx_idle_pct = 57;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_framebuffer(phase_w[ph], phase_h[ph]);
      if (ph == 1 || ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LINES; n++) send_line(random_line());
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> bresenham_line_rasterizer.f
src/brl_pkg.sv
src/brl_front.sv
src/brl_line_fifo.sv
src/brl_walker.sv
src/bresenham_line_rasterizer.sv
verif/tb_bresenham_line_rasterizer.sv
